@@ hw/rtl/sem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Command layout between front and back end, back-end state encoding,
// register indexes and the 3x3 kernel tables.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int DIM_W          = 11;
    localparam int PEND_W         = DIM_W + 1;
    localparam int CH_W           = 8;
    localparam int CH_N           = 3;
    localparam int ACC_W          = 12;
    localparam int SQ_W           = 21;
    localparam int ROOT_F_W       = 17;
    localparam int TAP_W          = 4;
    localparam int ROOT_BIT_W     = 3;
    localparam int CFG_IDX_W      = 1;

    localparam int CMD_DEPTH      = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_DEPTH + 1);

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    localparam logic [CH_W-1:0]       EDGE_CLAMP = 8'hFF;
    localparam logic [TAP_W-1:0]      TAP_LAST   = 4'd8;
    localparam logic [ROOT_BIT_W-1:0] ROOT_MSB   = 3'd7;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic              pixel;
        logic              emit;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [PEND_W-1:0] lag;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } sem_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE,
        ST_WRITE
    } sem_state_t;

    function automatic logic signed [2:0] kern_x(input logic [TAP_W-1:0] tap);
        unique case (tap)
            4'd0:    return -3'sd1;
            4'd1:    return 3'sd0;
            4'd2:    return 3'sd1;
            4'd3:    return -3'sd2;
            4'd4:    return 3'sd0;
            4'd5:    return 3'sd2;
            4'd6:    return -3'sd1;
            4'd7:    return 3'sd0;
            4'd8:    return 3'sd1;
            default: return 3'sd0;
        endcase
    endfunction

    function automatic logic signed [2:0] kern_y(input logic [TAP_W-1:0] tap);
        unique case (tap)
            4'd0:    return -3'sd1;
            4'd1:    return -3'sd2;
            4'd2:    return -3'sd1;
            4'd6:    return 3'sd1;
            4'd7:    return 3'sd2;
            4'd8:    return 3'sd1;
            default: return 3'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] tap_row_off(input logic [TAP_W-1:0] tap);
        priority if (tap < 4'd3)
            return -2'sd1;
        else if (tap < 4'd6)
            return 2'sd0;
        else
            return 2'sd1;
    endfunction

    function automatic logic signed [1:0] tap_col_off(input logic [TAP_W-1:0] tap);
        unique case (tap)
            4'd0, 4'd3, 4'd6: return -2'sd1;
            4'd2, 4'd5, 4'd8: return 2'sd1;
            default:          return 2'sd0;
        endcase
    endfunction

endpackage

@@ hw/rtl/sem_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_front: configuration registers and item classification
// Tracks pending results and the output raster position, decides per item
// whether a result is released and queues a command for the back end.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]            cfg_data,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 kind,
    input  logic [sem_pkg::CH_W-1:0]             red_in,
    input  logic [sem_pkg::CH_W-1:0]             green_in,
    input  logic [sem_pkg::CH_W-1:0]             blue_in,
    output sem_pkg::sem_cmd_t                    cmd,
    output logic                                 cmd_push
);
    import sem_pkg::*;

    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic [DIM_W-1:0]  out_row_reg;
    logic [DIM_W-1:0]  out_row_next;
    logic [DIM_W-1:0]  out_col_reg;
    logic [DIM_W-1:0]  out_col_next;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              accept;
    logic [PEND_W-1:0] pend_inc;
    logic [PEND_W-1:0] pend_dec;
    logic [PEND_W-1:0] row_inc;
    logic [PEND_W-1:0] col_inc;
    logic [PEND_W-1:0] need;
    logic              go_pixel;
    logic              go_flush;
    logic              emit;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_comb
    begin
        priority if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        priority if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    always_comb
    begin
        pend_inc = pending_reg + PEND_W'(1);
        pend_dec = pending_reg - PEND_W'(1);
        row_inc  = PEND_W'(out_row_reg) + PEND_W'(1);
        col_inc  = PEND_W'(out_col_reg) + PEND_W'(1);
        need     = ((row_inc < PEND_W'(h_eff)) ? PEND_W'(w_eff) : '0)
                 + ((col_inc < PEND_W'(w_eff)) ? PEND_W'(1) : '0);
        go_pixel = pend_inc > (PEND_W'(w_eff) + PEND_W'(1));
        go_flush = (pending_reg != '0) && (pend_dec >= need);
        emit     = (kind == KIND_PIXEL) ? go_pixel : go_flush;
    end

    always_comb
    begin
        pending_next = pending_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (accept)
        begin
            if (kind == KIND_PIXEL)
                pending_next = go_pixel ? pending_reg : pend_inc;
            else if (go_flush)
                pending_next = pend_dec;

            if (emit)
            begin
                if (col_inc >= PEND_W'(w_eff))
                begin
                    out_col_next = '0;
                    out_row_next = (row_inc >= PEND_W'(h_eff)) ? '0 : DIM_W'(row_inc);
                end
                else
                begin
                    out_col_next = DIM_W'(col_inc);
                end
            end
        end
    end

    always_comb
    begin
        cmd.pixel  = (kind == KIND_PIXEL);
        cmd.emit   = emit;
        cmd.red    = red_in;
        cmd.green  = green_in;
        cmd.blue   = blue_in;
        cmd.lag    = (kind == KIND_PIXEL) ? pending_reg : pend_dec;
        cmd.row    = out_row_reg;
        cmd.col    = out_col_reg;
        cmd.width  = w_eff;
        cmd.height = h_eff;
        cmd_push   = accept && ((kind == KIND_PIXEL) || go_flush);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            pending_reg      <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                endcase
            end
            pending_reg <= pending_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

endmodule

@@ hw/rtl/sem_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_cmd_fifo: command queue between front and back end
// Small flop-based FIFO; the head entry is presented while not empty.
// ----------------------------------------------------------------------------
module sem_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sem_pkg::sem_cmd_t wr_cmd,
    input  logic              rd_en,
    output sem_pkg::sem_cmd_t rd_cmd,
    output logic              full,
    output logic              empty
);
    import sem_pkg::*;

    sem_cmd_t               entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [CMD_CNT_W-1:0]   count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full   = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + CMD_CNT_W'(1);
                2'b01:   count_reg <= count_reg - CMD_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/sem_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_back: window fetch, Sobel sums, magnitude and result register
// Reads the 3x3 window one tap per cycle from the line memory, stores a pixel
// item, squares the gradients, then finds the rounded root bit by bit.
// ----------------------------------------------------------------------------
module sem_back #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sem_pkg::sem_cmd_t        cmd_head,
    input  logic                     cmd_empty,
    output logic                     cmd_pop,
    output logic                     empty,
    input  logic                     pop,
    output logic [sem_pkg::CH_W-1:0] red_edge,
    output logic [sem_pkg::CH_W-1:0] green_edge,
    output logic [sem_pkg::CH_W-1:0] blue_edge,
    output logic                     end_of_frame
);
    import sem_pkg::*;

    localparam int LINE_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int D_W        = PEND_W + 2;
    localparam int R_W        = DIM_W + 2;
    localparam int PX_W       = CH_N * CH_W;

    function automatic logic signed [ACC_W-1:0] weigh(input logic [CH_W-1:0] v,
                                                      input logic signed [2:0] k);
        logic signed [ACC_W-1:0] vs;
        vs = signed'(ACC_W'(v));
        unique case (k)
            3'b110:  return -(vs <<< 1);
            3'b111:  return -vs;
            3'b001:  return vs;
            3'b010:  return vs <<< 1;
            default: return '0;
        endcase
    endfunction

    logic [PX_W-1:0]         line_mem [LINE_DEPTH];
    logic [PX_W-1:0]         rdata_reg;

    sem_state_t              state_reg;
    sem_state_t              state_next;
    sem_cmd_t                cmd_reg;
    logic [TAP_W-1:0]        tap_reg;
    logic [AW-1:0]           wslot_reg;
    logic                    acc_vld_reg;
    logic                    acc_live_reg;
    logic [TAP_W-1:0]        acc_tap_reg;
    logic signed [ACC_W-1:0] gx_reg [CH_N];
    logic signed [ACC_W-1:0] gy_reg [CH_N];
    logic signed [ACC_W-1:0] gx_next [CH_N];
    logic signed [ACC_W-1:0] gy_next [CH_N];
    logic [SQ_W-1:0]         sq_reg [CH_N];
    logic [SQ_W-1:0]         sq_next [CH_N];
    logic [CH_W-1:0]         m_reg [CH_N];
    logic [CH_W-1:0]         m_next [CH_N];
    logic [ROOT_BIT_W-1:0]   root_bit_reg;
    logic                    out_vld_reg;
    logic [CH_W-1:0]         edge_reg [CH_N];
    logic [CH_W-1:0]         edge_next [CH_N];
    logic                    eof_reg;

    logic                    load;
    logic                    rd_en;
    logic                    wr_en;
    logic                    sq_load;
    logic                    root_step;
    logic                    res_push;

    logic signed [1:0]       dr;
    logic signed [1:0]       dc;
    logic signed [D_W-1:0]   w_s;
    logic signed [D_W-1:0]   wterm;
    logic signed [D_W-1:0]   tap_dist;
    logic signed [R_W-1:0]   rr;
    logic signed [R_W-1:0]   cc;
    logic                    tap_ok;
    logic                    tap_live;
    logic [AW:0]             back_u;
    logic [AW+1:0]           diff;
    logic [AW-1:0]           rd_addr;
    logic [PX_W-1:0]         px;
    logic [PX_W-1:0]         cur_px;
    logic signed [2*ACC_W-1:0] gx2;
    logic signed [2*ACC_W-1:0] gy2;
    logic [CH_W-1:0]         cand;
    logic [ROOT_F_W-1:0]     f_cand;
    logic                    eof_next;

    // window tap address and frame mask
    always_comb
    begin
        dr    = tap_row_off(tap_reg);
        dc    = tap_col_off(tap_reg);
        w_s   = signed'(D_W'(cmd_reg.width));
        unique case (dr)
            -2'sd1:  wterm = w_s;
            2'sd1:   wterm = -w_s;
            default: wterm = '0;
        endcase
        tap_dist = signed'(D_W'(cmd_reg.lag)) + wterm - D_W'(dc);
        rr       = signed'(R_W'(cmd_reg.row)) + R_W'(dr);
        cc       = signed'(R_W'(cmd_reg.col)) + R_W'(dc);
        tap_ok   = !rr[R_W-1] && (rr < signed'(R_W'(cmd_reg.height)))
                && !cc[R_W-1] && (cc < signed'(R_W'(cmd_reg.width)))
                && !tap_dist[D_W-1];
        tap_live = cmd_reg.pixel && (tap_dist == '0);
        back_u   = (AW+1)'(tap_dist) + (AW+1)'(!cmd_reg.pixel);
        diff     = (AW+2)'(wslot_reg) - (AW+2)'(back_u);
        rd_addr  = diff[AW+1] ? AW'(diff + (AW+2)'(LINE_DEPTH)) : AW'(diff);
    end

    // gradient accumulation, squares and root search
    always_comb
    begin
        cur_px   = {cmd_reg.red, cmd_reg.green, cmd_reg.blue};
        px       = acc_live_reg ? cur_px : rdata_reg;
        gx2      = '0;
        gy2      = '0;
        cand     = '0;
        f_cand   = '0;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            gx_next[ch] = gx_reg[ch];
            gy_next[ch] = gy_reg[ch];
            if (load)
            begin
                gx_next[ch] = '0;
                gy_next[ch] = '0;
            end
            else if (acc_vld_reg)
            begin
                gx_next[ch] = gx_reg[ch]
                            + weigh(px[PX_W-1-CH_W*ch -: CH_W], kern_x(acc_tap_reg));
                gy_next[ch] = gy_reg[ch]
                            + weigh(px[PX_W-1-CH_W*ch -: CH_W], kern_y(acc_tap_reg));
            end

            gx2         = gx_reg[ch] * gx_reg[ch];
            gy2         = gy_reg[ch] * gy_reg[ch];
            sq_next[ch] = SQ_W'(gx2) + SQ_W'(gy2);

            cand        = m_reg[ch] | (CH_W'(1) << root_bit_reg);
            f_cand      = ROOT_F_W'(cand) * ROOT_F_W'(cand) + ROOT_F_W'(cand);
            m_next[ch]  = m_reg[ch];
            if (sq_load)
                m_next[ch] = '0;
            else if (root_step && (SQ_W'(f_cand) < sq_reg[ch]))
                m_next[ch] = cand;

            if (sq_reg[ch] == '0)
                edge_next[ch] = '0;
            else if (m_reg[ch] == EDGE_CLAMP)
                edge_next[ch] = EDGE_CLAMP;
            else
                edge_next[ch] = m_reg[ch] + CH_W'(1);
        end
        eof_next = (cmd_reg.row == cmd_reg.height - DIM_W'(1))
                && (cmd_reg.col == cmd_reg.width - DIM_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                    state_next = cmd_head.emit ? ST_READ : ST_WRITE;
            end
            ST_READ:
            begin
                if (tap_reg == TAP_LAST)
                    state_next = ST_LAST;
            end
            ST_LAST:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (root_bit_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || pop)
                    state_next = ST_IDLE;
            end
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        load      = (state_reg == ST_IDLE) && !cmd_empty;
        rd_en     = (state_reg == ST_READ);
        wr_en     = ((state_reg == ST_LAST) && cmd_reg.pixel) || (state_reg == ST_WRITE);
        sq_load   = (state_reg == ST_SQUARE);
        root_step = (state_reg == ST_ROOT);
        res_push  = (state_reg == ST_DONE) && (!out_vld_reg || pop);
    end

    assign cmd_pop      = load;
    assign empty        = !out_vld_reg;
    assign red_edge     = edge_reg[0];
    assign green_edge   = edge_reg[1];
    assign blue_edge    = edge_reg[2];
    assign end_of_frame = eof_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wslot_reg] <= {cmd_reg.red, cmd_reg.green, cmd_reg.blue};
        if (rd_en)
            rdata_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd_head;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            gx_reg[ch] <= gx_next[ch];
            gy_reg[ch] <= gy_next[ch];
            m_reg[ch]  <= m_next[ch];
            if (sq_load)
                sq_reg[ch] <= sq_next[ch];
            if (res_push)
                edge_reg[ch] <= edge_next[ch];
        end
        if (res_push)
            eof_reg <= eof_next;
        acc_tap_reg  <= tap_reg;
        acc_live_reg <= tap_live;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            wslot_reg    <= '0;
            acc_vld_reg  <= 1'b0;
            root_bit_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_vld_reg <= rd_en && tap_ok;

            if (load)
                tap_reg <= '0;
            else if (rd_en)
                tap_reg <= tap_reg + TAP_W'(1);

            if (sq_load)
                root_bit_reg <= ROOT_MSB;
            else if (root_step)
                root_bit_reg <= root_bit_reg - ROOT_BIT_W'(1);

            if (wr_en)
                wslot_reg <= (wslot_reg == AW'(LINE_DEPTH - 1)) ? '0 : wslot_reg + AW'(1);

            if (res_push)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/sobel_edge_magnitude_rgb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top: streaming 3x3 Sobel edge magnitude on RGB
// Per-channel Sobel gradients with zero padding, rounded magnitude clamped
// at 255, results delayed by one row plus one pixel and drained by flushes.
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------
//   input     push / full          kind, red_in, green_in, blue_in
//   result    pop / empty          red_edge, green_edge, blue_edge,
//                                  end_of_frame
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item that releases a result occupies the back end for nine window reads
// through the single line-memory read port and eight root steps. A pixel that
// releases nothing only writes the line memory; a flush that releases nothing
// is not queued. Reset clears all control state; the line memory is not
// cleared. A 4-entry command queue lets input transfers continue while the
// back end works or waits for the result register to be popped.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          kind,
    input  logic [sem_pkg::CH_W-1:0]      red_in,
    input  logic [sem_pkg::CH_W-1:0]      green_in,
    input  logic [sem_pkg::CH_W-1:0]      blue_in,
    output logic                          empty,
    input  logic                          pop,
    output logic [sem_pkg::CH_W-1:0]      red_edge,
    output logic [sem_pkg::CH_W-1:0]      green_edge,
    output logic [sem_pkg::CH_W-1:0]      blue_edge,
    output logic                          end_of_frame
);
    import sem_pkg::*;

    sem_cmd_t front_cmd;
    sem_cmd_t head_cmd;
    logic     front_push;
    logic     cmd_empty;
    logic     cmd_pop;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cmd       (front_cmd),
        .cmd_push  (front_push)
    );

    sem_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .full   (full),
        .empty  (cmd_empty)
    );

    sem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_head     (head_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .empty        (empty),
        .pop          (pop),
        .red_edge     (red_edge),
        .green_edge   (green_edge),
        .blue_edge    (blue_edge),
        .end_of_frame (end_of_frame)
    );

endmodule

@@ hw/rtl/sem_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge magnitude block
// Watches the queue-style handshakes of the top level; bound to it below.
// ----------------------------------------------------------------------------
module sem_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     full,
    input logic                     empty,
    input logic                     pop,
    input logic [sem_pkg::CH_W-1:0] red_edge,
    input logic [sem_pkg::CH_W-1:0] green_edge,
    input logic [sem_pkg::CH_W-1:0] blue_edge,
    input logic                     end_of_frame
);

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(red_edge) && $stable(green_edge)
                              && $stable(blue_edge) && $stable(end_of_frame)))
        else $error("result changed while waiting");

    // back end needs many cycles per result: at most two transfers in a row
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) ##1 (pop && !empty) |=> empty)
        else $error("results delivered faster than the back end can make them");

endmodule

bind sobel_edge_magnitude_rgb_top sem_checker u_sem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .red_edge     (red_edge),
    .green_edge   (green_edge),
    .blue_edge    (blue_edge),
    .end_of_frame (end_of_frame)
);

@@ tb/sv/tb_sobel_edge_magnitude_rgb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb_top: self-checking bench for the Sobel edge block
// Streams whole RGB frames of many sizes, including zero sizes that saturate,
// through the push/full side. Flushes are mixed in to release pending results.
// Every result popped is compared field by field against a behavioral model
// of the line buffer and gradient math. Idling varies on both sides, and one
// long receiver hold-off forces input backpressure. Frame size registers
// change only while the block is drained.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb_top;
    import sem_pkg::*;

    localparam int LINE_DEPTH       = 2 * DEF_MAX_WIDTH + 2;
    localparam int SETTLE_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 100;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            eof;
    } edge_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic                 kind;
    logic [CH_W-1:0]      red_in;
    logic [CH_W-1:0]      green_in;
    logic [CH_W-1:0]      blue_in;
    logic                 empty;
    logic                 pop;
    logic [CH_W-1:0]      red_edge;
    logic [CH_W-1:0]      green_edge;
    logic [CH_W-1:0]      blue_edge;
    logic                 end_of_frame;

    // model state
    logic [DIM_W-1:0] cfg_w;
    logic [DIM_W-1:0] cfg_h;
    logic [23:0]      line_mem [LINE_DEPTH];
    int               wr_slot;
    int               pend_cnt;
    int               out_col;
    int               out_row;
    edge_res_t        edge_q [$];
    edge_res_t        want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int item_count     = 0;
    int mismatch_cnt   = 0;
    int idle_run;

    sobel_edge_magnitude_rgb_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .empty        (empty),
        .pop          (pop),
        .red_edge     (red_edge),
        .green_edge   (green_edge),
        .blue_edge    (blue_edge),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v < 1)
            return 1;
        if (v > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        logic [CH_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // 3x3 window around the oldest pending pixel; lag = pixels that came after it
    task automatic window_result(input bit live, input logic [23:0] cur, input int lag);
        int        w, h, dr, dc, rr, cc, d, back, wx, wy, ch, v, s, m;
        int        gx [3];
        int        gy [3];
        logic [23:0] px;
        edge_res_t res;
        w = eff_dim(cfg_w, DEF_MAX_WIDTH);
        h = eff_dim(cfg_h, DEF_MAX_HEIGHT);
        for (ch = 0; ch < CH_N; ch++)
        begin
            gx[ch] = 0;
            gy[ch] = 0;
        end
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                rr = out_row + dr;
                cc = out_col + dc;
                d  = lag - dr * w - dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w && d >= 0)
                begin
                    if (live && d == 0)
                        px = cur;
                    else
                    begin
                        back = live ? d : d + 1;
                        px = line_mem[(wr_slot + LINE_DEPTH - (back % LINE_DEPTH)) % LINE_DEPTH];
                    end
                    wx = dc * ((dr == 0) ? 2 : 1);
                    wy = dr * ((dc == 0) ? 2 : 1);
                    for (ch = 0; ch < CH_N; ch++)
                    begin
                        v = int'(px[23 - 8 * ch -: 8]);
                        gx[ch] += v * wx;
                        gy[ch] += v * wy;
                    end
                end
            end
        end
        for (ch = 0; ch < CH_N; ch++)
        begin
            s = gx[ch] * gx[ch] + gy[ch] * gy[ch];
            m = 0;
            while (m < int'(EDGE_CLAMP) && m * m + m < s)
                m++;
            case (ch)
                0:       res.red   = 8'(m);
                1:       res.green = 8'(m);
                default: res.blue  = 8'(m);
            endcase
        end
        res.eof = (out_row == h - 1) && (out_col == w - 1);
        edge_q.push_back(res);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
                out_row = 0;
        end
        pend_cnt--;
    endtask

    task automatic predict_item(input logic k, input logic [CH_W-1:0] r, g, b);
        int          w, h, lag, need;
        logic [23:0] cur;
        w   = eff_dim(cfg_w, DEF_MAX_WIDTH);
        h   = eff_dim(cfg_h, DEF_MAX_HEIGHT);
        cur = {r, g, b};
        if (k == KIND_PIXEL)
        begin
            pend_cnt++;
            if (pend_cnt > w + 1)
                window_result(1'b1, cur, pend_cnt - 1);
            line_mem[wr_slot] = cur;
            wr_slot = (wr_slot + 1) % LINE_DEPTH;
            item_count++;
        end
        else if (pend_cnt != 0)
        begin
            lag  = pend_cnt - 1;
            need = ((out_row + 1 < h) ? w : 0) + ((out_col + 1 < w) ? 1 : 0);
            if (lag >= need)
            begin
                window_result(1'b0, 24'd0, lag);
                item_count++;
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic k, input logic [CH_W-1:0] r, g, b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        kind     <= k;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(k, r, g, b);
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        push      <= 1'b0;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            cfg_index <= (i == 0) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT;
            cfg_data  <= (i == 0) ? w : h;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (i == 0)
                cfg_w = w;
            else
                cfg_h = h;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int s, input int r);
        push <= 1'b0;
        @(posedge clk);
        send_idle_pct  = s;
        recv_stall_pct = r;
        @(negedge clk);
    endtask

    task automatic send_frame(input int flush_pct);
        int n;
        n = eff_dim(cfg_w, DEF_MAX_WIDTH) * eff_dim(cfg_h, DEF_MAX_HEIGHT);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                send_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
            send_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    task automatic drain();
        while (pend_cnt > 0)
            send_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (edge_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic test_idle_flush();
        send_item(KIND_FLUSH, 8'hFF, 8'h00, 8'hFF);
        send_item(KIND_FLUSH, 8'h00, 8'hFF, 8'h00);
        wait_idle();
    endtask

    // zero sizes saturate to a single pixel frame
    task automatic test_min_frame();
        set_frame('0, '0);
        send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        drain();
        wait_idle();
    endtask

    task automatic test_checkerboard();
        int          r, c;
        logic [CH_W-1:0] on;
        set_frame(11'd3, 11'd3);
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                on = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
                send_item(KIND_PIXEL, on, ~on, (c == 1) ? 8'hFF : 8'h00);
                if (r == 0 && c == 1)
                    send_item(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);
            end
        end
        drain();
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_frame(11'd8, 11'd6);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        send_frame(0);
        drain();
        wait_idle();
    endtask

    task automatic test_random(input int s, input int r);
        int start;
        set_idling(s, r);
        start = item_count;
        while (item_count - start < RANDOM_PER_PHASE)
        begin
            set_frame(($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 9)),
                      11'($urandom_range(1, 6)));
            repeat ($urandom_range(1, 3))
                send_frame(10);
            drain();
            send_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
            wait_idle();
        end
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (edge_q.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: r=%0d g=%0d b=%0d eof=%0b",
                             red_edge, green_edge, blue_edge, end_of_frame);
                mismatch_cnt++;
            end
            else
            begin
                want = edge_q.pop_front();
                if (red_edge !== want.red || green_edge !== want.green ||
                    blue_edge !== want.blue || end_of_frame !== want.eof)
                begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.red, want.green, want.blue, want.eof,
                                 red_edge, green_edge, blue_edge, end_of_frame);
                    mismatch_cnt++;
                end
            end
        end
    end

    // cycles without any transfer on any channel
    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb_sobel_edge_magnitude_rgb_top: errors");
        $finish;
    end

    initial
    begin
        foreach (line_mem[i])
            line_mem[i] = '0;
        cfg_w     = RST_FRAME_WIDTH;
        cfg_h     = RST_FRAME_HEIGHT;
        wr_slot   = 0;
        pend_cnt  = 0;
        out_col   = 0;
        out_row   = 0;
        rst_n     = 1'b0;
        push      = 1'b0;
        kind      = KIND_PIXEL;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_flush();
        test_min_frame();
        test_checkerboard();
        test_backpressure();
        test_random(0, 0);
        test_random(85, 0);
        test_random(0, 85);
        test_random(9, 9);
        wait_idle();

        mismatch_cnt += edge_q.size();
        if (mismatch_cnt == 0)
            $display("tb_sobel_edge_magnitude_rgb_top: clean");
        else
            $display("tb_sobel_edge_magnitude_rgb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sem_pkg.sv
hw/rtl/sem_front.sv
hw/rtl/sem_cmd_fifo.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude_rgb_top.sv
hw/rtl/sem_checker.sv
tb/sv/tb_sobel_edge_magnitude_rgb_top.sv
